FILE: hw/rtl/pzc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pzc_pkg
// types, constants and small lookup functions for the zip / bar pattern codec
// ----------------------------------------------------------------------------
package pzc_pkg;

  localparam int unsigned BarW    = 27;
  localparam int unsigned ZipW    = 17;
  localparam int unsigned GroupW  = 5;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned NumDigits = 5;

  localparam logic [ZipW-1:0] ZipMax = 17'd99999;

  // reciprocal of 1000: q = (x * 134218) >> 27, exact for every 17-bit x
  localparam logic [17:0] RecipDiv1000 = 18'd134218;
  // reciprocal of 10: q = (x * 205) >> 11, exact for x below 1029
  localparam logic [7:0]  RecipDiv10   = 8'd205;
  // reciprocal of 100: q = (x * 41) >> 12, exact for x below 1000
  localparam logic [5:0]  RecipDiv100  = 6'd41;

  typedef enum logic {
    MODE_DECODE = 1'b0,
    MODE_ENCODE = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FRAME = 2'd1,
    STAT_GROUP = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

  typedef logic [NumDigits-1:0][DigitW-1:0] digits_t;

  // weights 7,4,2,1,0 from the first bar down; a sum of 11 stands for zero
  function automatic logic [DigitW-1:0] group_digit(input logic [GroupW-1:0] grp);
    logic [DigitW-1:0] sum;
    sum = (grp[4] ? 4'd7 : 4'd0) + (grp[3] ? 4'd4 : 4'd0)
        + (grp[2] ? 4'd2 : 4'd0) + (grp[1] ? 4'd1 : 4'd0);
    return (sum == 4'd11) ? 4'd0 : sum;
  endfunction

  function automatic logic two_of_five(input logic [GroupW-1:0] grp);
    return ($countones(grp) == 2);
  endfunction

  function automatic logic [GroupW-1:0] digit_pattern(input logic [DigitW-1:0] d);
    logic [GroupW-1:0] pat;
    unique case (d)
      4'd0:    pat = 5'b11000;
      4'd1:    pat = 5'b00011;
      4'd2:    pat = 5'b00101;
      4'd3:    pat = 5'b00110;
      4'd4:    pat = 5'b01001;
      4'd5:    pat = 5'b01010;
      4'd6:    pat = 5'b01100;
      4'd7:    pat = 5'b10001;
      4'd8:    pat = 5'b10010;
      4'd9:    pat = 5'b10100;
      default: pat = 5'b00000;
    endcase
    return pat;
  endfunction

endpackage

FILE: hw/rtl/postnet_zip_codec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postnet_zip_codec
// four-stage pipelined converter between a five-digit zip code and a
// framed 27-bit two-of-five bar pattern, in both directions
// ----------------------------------------------------------------------------
//
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+------------------------
//  command   | mode_i, bar_bits_i, zip_value_i         | start_i high, busy_o low
//  result    | zip_out_o, bar_out_o, status_o          | valid_o strobe, 1 cycle
//
//  one item can enter every cycle; busy_o is never raised
//  each result passes the stage 1, 2 and 3 registers into the output registers,
//  and results leave in order
//  the four stages are set by the constant-reciprocal divide chain of encode
//  reset clears only the stage valid bits; data registers are not reset
//  the receiver cannot stall, so results leave on their strobe cycle
//
module postnet_zip_codec
  import pzc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  logic            mode_i,
  input  logic [BarW-1:0] bar_bits_i,
  input  logic [ZipW-1:0] zip_value_i,
  output logic            valid_o,
  output logic [ZipW-1:0] zip_out_o,
  output logic [BarW-1:0] bar_out_o,
  output logic [1:0]      status_o
);

  logic accept;

  // the pipeline never backs up, so commands are always welcome
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // --------------------------------------------------------------------------
  // valid bits, one per stage
  // --------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: frame and group checks, group digits; encode range check and
  // the top split zip / 1000
  // --------------------------------------------------------------------------
  mode_e           s1_mode_d, s1_mode_q;
  status_e         s1_stat_d, s1_stat_q;
  digits_t         s1_dig_d, s1_dig_q;
  logic [ZipW-1:0] s1_zip_q;
  logic [7:0]      s1_hi_d, s1_hi_q;
  logic [34:0]     s1_prod;
  logic            groups_ok;

  always_comb begin
    s1_mode_d = mode_e'(mode_i);
    groups_ok = 1'b1;
    for (int g = 0; g < NumDigits; g++) begin
      // digit 0 is the most significant, right behind the first frame bar
      s1_dig_d[g] = group_digit(bar_bits_i[BarW-2-GroupW*g -: GroupW]);
      if (!two_of_five(bar_bits_i[BarW-2-GroupW*g -: GroupW])) begin
        groups_ok = 1'b0;
      end
    end

    s1_prod = 35'(zip_value_i) * 35'(RecipDiv1000);
    s1_hi_d = s1_prod[34:27];

    if (s1_mode_d == MODE_DECODE) begin
      if (!bar_bits_i[BarW-1] || !bar_bits_i[0]) begin
        s1_stat_d = STAT_FRAME;
      end else if (!groups_ok) begin
        s1_stat_d = STAT_GROUP;
      end else begin
        s1_stat_d = STAT_OK;
      end
    end else begin
      s1_stat_d = (zip_value_i > ZipMax) ? STAT_RANGE : STAT_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mode_q <= s1_mode_d;
      s1_stat_q <= s1_stat_d;
      s1_dig_q  <= s1_dig_d;
      s1_zip_q  <= zip_value_i;
      s1_hi_q   <= s1_hi_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: decode pairs digits into two-digit values; encode takes the low
  // three digits as a remainder and splits the top two by ten
  // --------------------------------------------------------------------------
  mode_e      s2_mode_q;
  status_e    s2_stat_q;
  logic [7:0] s2_pair_a_d, s2_pair_a_q, s2_pair_b_d, s2_pair_b_q;
  logic [3:0] s2_last_q;
  logic [9:0] s2_lo_d, s2_lo_q;
  logic [7:0] s2_hi_q;
  logic [4:0] s2_t_d, s2_t_q;
  logic [17:0] s2_lo_full;
  logic [15:0] s2_t_prod;

  always_comb begin
    s2_pair_a_d = 8'(s1_dig_q[0]) * 8'd10 + 8'(s1_dig_q[1]);
    s2_pair_b_d = 8'(s1_dig_q[2]) * 8'd10 + 8'(s1_dig_q[3]);
    s2_lo_full  = 18'(s1_zip_q) - 18'(s1_hi_q) * 18'd1000;
    s2_lo_d     = s2_lo_full[9:0];
    s2_t_prod   = 16'(s1_hi_q) * 16'(RecipDiv10);
    s2_t_d      = s2_t_prod[15:11];
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_mode_q   <= s1_mode_q;
      s2_stat_q   <= s1_stat_q;
      s2_pair_a_q <= s2_pair_a_d;
      s2_pair_b_q <= s2_pair_b_d;
      s2_last_q   <= s1_dig_q[4];
      s2_lo_q     <= s2_lo_d;
      s2_hi_q     <= s1_hi_q;
      s2_t_q      <= s2_t_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: decode forms the binary zip; encode finishes the second digit
  // and divides the low part by 100 and by 10
  // --------------------------------------------------------------------------
  mode_e           s3_mode_q;
  status_e         s3_stat_q;
  logic [ZipW-1:0] s3_zip_d, s3_zip_q;
  logic [17:0]     s3_zip_full;
  logic [3:0]      s3_d0_q, s3_d1_d, s3_d1_q, s3_h_d, s3_h_q;
  logic [6:0]      s3_l10_d, s3_l10_q;
  logic [9:0]      s3_lo_q;
  logic [7:0]      s3_d1_full;
  logic [15:0]     s3_h_prod;
  logic [17:0]     s3_l10_prod;

  always_comb begin
    s3_zip_full = 18'(s2_pair_a_q) * 18'd1000 + 18'(s2_pair_b_q) * 18'd10
                + 18'(s2_last_q);
    s3_zip_d    = s3_zip_full[ZipW-1:0];
    s3_d1_full  = s2_hi_q - 8'(s2_t_q) * 8'd10;
    s3_d1_d     = s3_d1_full[3:0];
    s3_h_prod   = 16'(s2_lo_q) * 16'(RecipDiv100);
    s3_h_d      = s3_h_prod[15:12];
    s3_l10_prod = 18'(s2_lo_q) * 18'(RecipDiv10);
    s3_l10_d    = s3_l10_prod[17:11];
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      s3_mode_q <= s2_mode_q;
      s3_stat_q <= s2_stat_q;
      s3_zip_q  <= s3_zip_d;
      s3_d0_q   <= s2_t_q[3:0];
      s3_d1_q   <= s3_d1_d;
      s3_h_q    <= s3_h_d;
      s3_l10_q  <= s3_l10_d;
      s3_lo_q   <= s2_lo_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: last two encode digits, pattern lookup, framing and error gating
  // into the output registers
  // --------------------------------------------------------------------------
  logic [3:0]      s4_d3, s4_d4;
  logic [6:0]      s4_d3_full;
  logic [9:0]      s4_d4_full;
  logic [BarW-1:0] s4_bar;
  logic [ZipW-1:0] zip_out_d, zip_out_q;
  logic [BarW-1:0] bar_out_d, bar_out_q;
  status_e         status_q;

  always_comb begin
    s4_d3_full = s3_l10_q - 7'(s3_h_q) * 7'd10;
    s4_d3      = s4_d3_full[3:0];
    s4_d4_full = s3_lo_q - 10'(s3_l10_q) * 10'd10;
    s4_d4      = s4_d4_full[3:0];
    s4_bar     = {1'b1, digit_pattern(s3_d0_q), digit_pattern(s3_d1_q),
                  digit_pattern(s3_h_q), digit_pattern(s4_d3),
                  digit_pattern(s4_d4), 1'b1};

    // the field of the other mode, and both fields on error, read zero
    zip_out_d = (s3_mode_q == MODE_DECODE && s3_stat_q == STAT_OK) ? s3_zip_q : '0;
    bar_out_d = (s3_mode_q == MODE_ENCODE && s3_stat_q == STAT_OK) ? s4_bar : '0;
  end

  always_ff @(posedge clk_i) begin
    if (s3_valid_q) begin
      zip_out_q <= zip_out_d;
      bar_out_q <= bar_out_d;
      status_q  <= s3_stat_q;
    end
  end

  assign valid_o   = s4_valid_q;
  assign zip_out_o = zip_out_q;
  assign bar_out_o = bar_out_q;
  assign status_o  = status_q;

endmodule

FILE: tb/postnet_zip_codec_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postnet_zip_codec_tb
// self-checking bench for the zip / bar pattern codec: directed corner items
// then ~400 random items (mostly well-formed bar patterns and in-range zips),
// sent in random bursts; every result is checked against an in-bench model
// ----------------------------------------------------------------------------
module postnet_zip_codec_tb;
  import pzc_pkg::*;

  localparam int unsigned ClkPeriod   = 8;
  localparam int unsigned RandomItems = 400;
  localparam int unsigned IdleLimit   = 2000;  // cycles with no item in or out
  localparam int unsigned TailCycles  = 12;    // pipeline is 4 deep
  localparam int unsigned ShowErrors  = 10;

  // first bar of each group carries weight 7, then 4, 2, 1, 0
  localparam int unsigned BarWeight [5] = '{7, 4, 2, 1, 0};
  // tall/short pattern of one group per decimal digit, first bar in the msb
  localparam logic [GroupW-1:0] DigitBars [10] = '{
    5'b11000, 5'b00011, 5'b00101, 5'b00110, 5'b01001,
    5'b01010, 5'b01100, 5'b10001, 5'b10010, 5'b10100
  };

  typedef struct {
    mode_e           mode;
    logic [BarW-1:0] bars;
    logic [ZipW-1:0] zip;
    bit              drain;  // hold this item back until the pipeline is empty
  } codec_cmd_t;

  typedef struct {
    logic [ZipW-1:0] zip_out;
    logic [BarW-1:0] bar_out;
    status_e         status;
  } codec_result_t;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            start_i     = 1'b0;
  mode_e           mode_i      = MODE_DECODE;
  logic [BarW-1:0] bar_bits_i  = '0;
  logic [ZipW-1:0] zip_value_i = '0;
  logic            busy_o;
  logic            valid_o;
  logic [ZipW-1:0] zip_out_o;
  logic [BarW-1:0] bar_out_o;
  logic [1:0]      status_o;

  codec_cmd_t    cmd_q[$];      // items waiting to be sent
  codec_result_t conv_q[$];     // expected conversions, oldest first
  int            sent_cnt  = 0;
  int            got_cnt   = 0;
  int            err_cnt   = 0;
  int            idle_cyc  = 0;
  int            burst_left = 0;
  int            gap_left   = 0;

  wire take = start_i && !busy_o;

  postnet_zip_codec dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .mode_i      (mode_i),
    .bar_bits_i  (bar_bits_i),
    .zip_value_i (zip_value_i),
    .valid_o     (valid_o),
    .zip_out_o   (zip_out_o),
    .bar_out_o   (bar_out_o),
    .status_o    (status_o)
  );

  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // conversion model
  // --------------------------------------------------------------------------
  function automatic codec_result_t convert_zip_bars(mode_e m, logic [BarW-1:0] bars,
                                                     logic [ZipW-1:0] zip);
    codec_result_t r;
    logic [GroupW-1:0] grp;
    logic [31:0] pat;
    int unsigned sum, val, rest, div, d;
    bit groups_ok;
    r.zip_out = '0;
    r.bar_out = '0;
    r.status  = STAT_OK;
    if (m == MODE_DECODE) begin
      // frame bars are checked first; groups are not looked at without them
      if (!bars[BarW-1] || !bars[0]) begin
        r.status = STAT_FRAME;
      end else begin
        groups_ok = 1'b1;
        val = 0;
        for (int g = 0; g < NumDigits; g++) begin
          grp = bars[25 - 5*g -: 5];
          if ($countones(grp) != 2) groups_ok = 1'b0;
          sum = 0;
          for (int k = 0; k < GroupW; k++) begin
            if (grp[4-k]) sum += BarWeight[k];
          end
          // 7 + 4 is the code for zero
          val = val * 10 + ((sum == 11) ? 0 : sum);
        end
        if (!groups_ok) r.status = STAT_GROUP;
        else r.zip_out = ZipW'(val);
      end
    end else begin
      if (zip > ZipMax) begin
        r.status = STAT_RANGE;
      end else begin
        rest = zip;
        div  = 10000;
        pat  = 32'd1;  // leading frame bar
        for (int g = 0; g < NumDigits; g++) begin
          d    = rest / div;
          rest = rest % div;
          div  = div / 10;
          pat  = (pat << GroupW) | DigitBars[d];
        end
        r.bar_out = BarW'((pat << 1) | 32'd1);  // trailing frame bar
      end
    end
    return r;
  endfunction

  // well-formed bar pattern of an in-range zip
  function automatic logic [BarW-1:0] zip_bars(logic [ZipW-1:0] zip);
    codec_result_t r;
    r = convert_zip_bars(MODE_ENCODE, '0, zip);
    return r.bar_out;
  endfunction

  task automatic queue_cmd(mode_e m, logic [BarW-1:0] bars, logic [ZipW-1:0] zip,
                           bit drain = 1'b0);
    codec_cmd_t c;
    c.mode  = m;
    c.bars  = bars;
    c.zip   = zip;
    c.drain = drain;
    cmd_q.push_back(c);
  endtask

  // --------------------------------------------------------------------------
  // driver: random bursts separated by random gaps, holds items on busy
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    int outstanding;
    codec_cmd_t c;
    if (!rst_ni) begin
      start_i    <= 1'b0;
      burst_left <= $urandom_range(1, 8);
      gap_left   <= 0;
    end else begin
      if (take) sent_cnt <= sent_cnt + 1;
      // counters are updated nonblocking, so count this edge's traffic by hand
      outstanding = sent_cnt + int'(take) - got_cnt - int'(valid_o);
      if (start_i && !take) begin
        // item not taken yet: keep it on the ports
      end else if (gap_left != 0) begin
        start_i  <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (cmd_q.size() != 0 && !(cmd_q[0].drain && outstanding != 0)) begin
        c = cmd_q.pop_front();
        start_i     <= 1'b1;
        mode_i      <= c.mode;
        bar_bits_i  <= c.bars;
        zip_value_i <= c.zip;
        if (burst_left <= 1) begin
          // one burst in four is long, giving stretches with no idle cycles
          burst_left <= ($urandom_range(3) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 8);
          gap_left   <= $urandom_range(1, 10);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: predicts on every taken item, checks every result strobe
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    codec_result_t want;
    if (rst_ni) begin
      if (take) conv_q.push_back(convert_zip_bars(mode_i, bar_bits_i, zip_value_i));
      if (valid_o) begin
        got_cnt <= got_cnt + 1;
        if (conv_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= ShowErrors)
            $display("[%0t] unexpected result: zip %0d bar %h status %0d",
                     $realtime, zip_out_o, bar_out_o, status_o);
        end else begin
          want = conv_q.pop_front();
          if (zip_out_o !== want.zip_out || bar_out_o !== want.bar_out ||
              status_o !== want.status) begin
            err_cnt++;
            if (err_cnt <= ShowErrors)
              $display("[%0t] mismatch: zip %0d/%0d bar %h/%h status %0d/%0d (exp/act)",
                       $realtime, want.zip_out, zip_out_o, want.bar_out, bar_out_o,
                       want.status, status_o);
          end
        end
      end
    end
  end

  // watchdog: nothing in and nothing out for too long means a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (take || valid_o) idle_cyc <= 0;
      else idle_cyc <= idle_cyc + 1;
      if (idle_cyc >= IdleLimit) begin
        $display("[%0t] timeout, %0d conversions outstanding", $realtime, conv_q.size());
        $display("postnet_zip_codec_tb: FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of test
  // --------------------------------------------------------------------------
  initial begin
    logic [BarW-1:0] bars;
    logic [ZipW-1:0] zip;
    int unsigned pick;

    // well-formed patterns: both extremes, every digit at least once
    queue_cmd(MODE_DECODE, zip_bars(17'd0), '1);
    queue_cmd(MODE_DECODE, zip_bars(17'd99999), '0);
    queue_cmd(MODE_DECODE, zip_bars(17'd1234), '0);
    queue_cmd(MODE_DECODE, zip_bars(17'd56789), '0);
    queue_cmd(MODE_DECODE, zip_bars(17'd43210), '0);
    queue_cmd(MODE_DECODE, zip_bars(17'd98765), '0);
    // frame bar missing: none, first, last, both with bad groups behind
    queue_cmd(MODE_DECODE, '0, '0);
    queue_cmd(MODE_DECODE, zip_bars(17'd12345) & ~27'h4000000, '0);
    queue_cmd(MODE_DECODE, zip_bars(17'd12345) & ~27'h1, '0);
    queue_cmd(MODE_DECODE, 27'h3FFFFFE, '0);
    // frame fine, group counts wrong: all tall, all short, one group off by one (last, then first)
    queue_cmd(MODE_DECODE, '1, '0);
    queue_cmd(MODE_DECODE, 27'h4000001, '0);
    queue_cmd(MODE_DECODE, zip_bars(17'd90210) ^ 27'h20, '0);
    queue_cmd(MODE_DECODE, zip_bars(17'd90210) ^ 27'h2000000, '0);
    // encode: range ends, just past the top, largest input, unused bars all tall
    queue_cmd(MODE_ENCODE, '1, 17'd0);
    queue_cmd(MODE_ENCODE, '0, 17'd99999);
    queue_cmd(MODE_ENCODE, '0, 17'd100000);
    queue_cmd(MODE_ENCODE, '1, 17'h1FFFF);
    queue_cmd(MODE_ENCODE, '0, 17'd12345);
    queue_cmd(MODE_ENCODE, '0, 17'd67890, 1'b1);  // waits for the pipeline to drain
    queue_cmd(MODE_DECODE, zip_bars(17'd67890), '0);

    for (int i = 0; i < RandomItems; i++) begin
      pick = $urandom_range(99);
      bars = BarW'($urandom);
      zip  = ZipW'($urandom);
      if (pick < 40) begin
        // well-formed pattern, sometimes with one or two bars flipped
        bars = zip_bars(ZipW'($urandom_range(99999)));
        if ($urandom_range(5) == 0) begin
          bars ^= BarW'(1) << $urandom_range(BarW-1);
          if ($urandom_range(1) == 0) bars ^= BarW'(1) << $urandom_range(BarW-1);
        end
        queue_cmd(MODE_DECODE, bars, zip, (i % 97) == 96);
      end else if (pick < 52) begin
        queue_cmd(MODE_DECODE, bars, zip, (i % 97) == 96);
      end else if (pick < 88) begin
        queue_cmd(MODE_ENCODE, bars, ZipW'($urandom_range(99999)), (i % 97) == 96);
      end else begin
        queue_cmd(MODE_ENCODE, bars, zip, (i % 97) == 96);
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // everything sent and every conversion back
    while (cmd_q.size() != 0 || start_i || conv_q.size() != 0) @(negedge clk_i);
    // catch stray strobes after the last expected one
    repeat (TailCycles) @(negedge clk_i);

    if (conv_q.size() != 0) $display("%0d conversions never returned", conv_q.size());
    if (err_cnt == 0 && conv_q.size() == 0) begin
      $display("postnet_zip_codec_tb: PASS");
    end else begin
      $display("postnet_zip_codec_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: postnet_zip_codec.f
hw/rtl/pzc_pkg.sv
hw/rtl/postnet_zip_codec.sv
tb/postnet_zip_codec_tb.sv
